// ----- rtl/core/rcd_pkg.sv -----
package rcd_pkg;

  localparam int DATA_W = 32;
  // Count and capacity width: holds up to 64 entries.
  localparam int CNT_W = 7;

  localparam logic [2:0] OP_INS_REAR  = 3'd0;
  localparam logic [2:0] OP_INS_FRONT = 3'd1;
  localparam logic [2:0] OP_DEL_FRONT = 3'd2;
  localparam logic [2:0] OP_DEL_REAR  = 3'd3;
  localparam logic [2:0] OP_TRAVERSE  = 3'd4;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_FULL        = 2'd1;
  localparam logic [1:0] STAT_EMPTY       = 2'd2;
  localparam logic [1:0] STAT_NOT_ALLOWED = 2'd3;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_MODE     = 1'b1;

  localparam logic MODE_IN_RESTRICT  = 1'b0;
  localparam logic MODE_OUT_RESTRICT = 1'b1;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_BACK,
    CMD_PUSH_FRONT,
    CMD_POP_FRONT,
    CMD_ROTATE
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [CNT_W-1:0]  cnt;
    logic [DATA_W-1:0] data;
  } cell_bus_t;

endpackage

// ----- rtl/core/rcd_cell.sv -----
module rcd_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  rcd_pkg::cell_bus_t        bus,
  input  logic [rcd_pkg::DATA_W-1:0] left,
  input  logic [rcd_pkg::DATA_W-1:0] right,
  output logic [rcd_pkg::DATA_W-1:0] entry,
  output logic [rcd_pkg::DATA_W-1:0] tail_data
);
  import rcd_pkg::*;

  localparam logic [CNT_W-1:0] POS      = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(IDX + 1);

  logic [DATA_W-1:0] entry_next;
  logic              is_tail;

  assign is_tail   = (bus.cnt == POS_NEXT);
  assign tail_data = is_tail ? entry : '0;

  always_comb begin
    entry_next = entry;
    case (bus.cmd)
      CMD_PUSH_BACK: begin
        if (bus.cnt == POS) entry_next = bus.data;
      end
      CMD_PUSH_FRONT: begin
        // cell 0 sees the new value on its left input
        entry_next = left;
      end
      CMD_POP_FRONT: begin
        entry_next = right;
      end
      CMD_ROTATE: begin
        // tail cell takes the old head, the rest move one toward the front
        entry_next = is_tail ? bus.data : right;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ----- rtl/core/restricted_circular_deque.sv -----
// Restricted circular deque.
// Input channel (in_valid/in_stall) carries op and value; each transfer is one
// operation. Output channel (out_valid/out_stall) carries value_out, status and
// last. Configuration channel (cfg_valid/cfg_ready, always ready) writes
// capacity (index 0, taken only while empty) and restriction_mode (index 1).
// Storage is a chain of DEPTH cells kept packed from the head in cell 0; the
// cells shift toward or away from the head as items enter or leave.
// An insert or delete result appears in the output register in the cycle after
// its op is taken. Inserts and deletes are taken at one op per cycle while the
// output is drained every cycle.
// Traverse of N stored entries: the accepting cycle starts the walk, then one
// result per cycle follows while the output is not stalled; input is stalled
// until the walk ends. The chain rotates one cell per result and is back in
// place at the end.
// When the receiver stalls, the output register holds its result and the
// input is stalled until the result is taken; traverse pauses in place.
// Reset (rst, synchronous) empties the deque, sets capacity to DEPTH and the
// mode to output-restricted. No clearing pass is needed.
module restricted_circular_deque #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic signed [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] value_out,
  output logic [1:0]  status,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import rcd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_TRAV = 2'b10
  } state_t;

  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(DEPTH);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  remaining, remaining_next;
  logic [CNT_W-1:0]  cap_eff;
  logic              mode;

  logic              in_accept;
  logic              out_free;
  logic              allowed;
  logic              load_out;
  logic [DATA_W-1:0] res_value;
  logic [1:0]        res_status;
  logic              res_last;
  cmd_t              cmd;
  cell_bus_t         bus;

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_tail [DEPTH];
  logic [DATA_W-1:0] head;
  logic [DATA_W-1:0] tail;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;
  assign head      = cell_data[0];

  always_comb begin
    tail = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail = tail | cell_tail[i];
    end
  end

  always_comb begin
    allowed = (op inside {[OP_INS_REAR:OP_TRAVERSE]});
    if (op == OP_INS_FRONT && mode == MODE_IN_RESTRICT) allowed = 1'b0;
    if (op == OP_DEL_REAR && mode == MODE_OUT_RESTRICT) allowed = 1'b0;
  end

  always_comb begin
    cmd            = CMD_HOLD;
    count_next     = count;
    remaining_next = remaining;
    state_next     = state;
    load_out       = 1'b0;
    res_value      = '0;
    res_status     = STAT_OK;
    res_last       = 1'b1;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          load_out = 1'b1;
          if (!allowed) begin
            res_status = STAT_NOT_ALLOWED;
          end else if (op inside {OP_INS_REAR, OP_INS_FRONT}) begin
            if (count == cap_eff) begin
              res_status = STAT_FULL;
            end else begin
              cmd        = (op == OP_INS_REAR) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
              count_next = count + CNT_W'(1);
            end
          end else if (count == '0) begin
            res_status = STAT_EMPTY;
          end else if (op == OP_DEL_FRONT) begin
            res_value  = head;
            cmd        = CMD_POP_FRONT;
            count_next = count - CNT_W'(1);
          end else if (op == OP_DEL_REAR) begin
            // rear entry simply drops out of the packed range
            res_value  = tail;
            count_next = count - CNT_W'(1);
          end else begin
            load_out       = 1'b0;
            state_next     = ST_TRAV;
            remaining_next = count;
          end
        end
      end
      ST_TRAV: begin
        if (out_free) begin
          load_out       = 1'b1;
          res_value      = head;
          res_last       = (remaining == CNT_W'(1));
          cmd            = CMD_ROTATE;
          remaining_next = remaining - CNT_W'(1);
          if (remaining == CNT_W'(1)) state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign bus.cmd  = cmd;
  assign bus.cnt  = count;
  assign bus.data = (state == ST_TRAV) ? head : DATA_W'(value);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = bus.data;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    rcd_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .bus      (bus),
      .left     (left_in),
      .right    (right_in),
      .entry    (cell_data[i]),
      .tail_data(cell_tail[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      value_out <= res_value;
      status    <= res_status;
      last      <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_eff <= CAP_MAX;
      mode    <= MODE_OUT_RESTRICT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CAPACITY: begin
          if (count == '0) begin
            if (cfg_data == '0) begin
              cap_eff <= CNT_W'(1);
            end else if (cfg_data > CAP_MAX) begin
              cap_eff <= CAP_MAX;
            end else begin
              cap_eff <= cfg_data;
            end
          end
        end
        CFG_MODE: begin
          mode <= cfg_data[0];
        end
        default: begin
          mode <= mode;
        end
      endcase
    end
  end

  a_count_in_cap: assert property (@(posedge clk) disable iff (rst)
    count <= cap_eff)
    else $error("entry count exceeds capacity");

  a_trav_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_TRAV |-> (count != '0 && remaining != '0 && remaining <= count))
    else $error("traverse running with bad remaining count");

  a_pop_front_count: assert property (@(posedge clk) disable iff (rst)
    (in_accept && allowed && op == OP_DEL_FRONT && count != '0)
      |=> count == $past(count) - CNT_W'(1))
    else $error("front delete did not shrink the deque");

  a_trav_keeps_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_TRAV |=> $stable(count))
    else $error("count changed during traverse");

endmodule

// ----- tb/restricted_circular_deque_tb.sv -----
`timescale 1ns / 1ps

module restricted_circular_deque_tb;
  import rcd_pkg::*;

  localparam int RING_DEPTH = 64;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int RANDOM_OPS = 430;
  // op codes past traverse have no name in the package
  localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [2:0] OP_RSVD_LAST = 3'd7;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [1:0] status;
    logic last;
  } deque_result_t;

  typedef enum logic { ROW_OP, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [2:0] opc;
    logic idx;
    logic [31:0] data;
    logic typed;
    logic [1:0] st;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] op = OP_INS_REAR;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] value_out;
  logic [1:0] status;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_CAPACITY;
  logic [6:0] cfg_data = '0;

  restricted_circular_deque DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value_out(value_out),
    .status(status),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [31:0] ring_mem [RING_DEPTH];
  logic [5:0] head_idx;
  logic [5:0] tail_idx;
  logic dq_empty;
  logic [6:0] cap_reg;
  logic mode_reg;

  deque_result_t results_due[$];
  stim_row_t dir_rows[$];
  deque_result_t seen_exp;
  int errors = 0;
  int cycle_count = 0;
  int stall_left = 0;
  int calm_left = 0;
  int burst_left = 0;
  int pick_out;

  function automatic int live_cap();
    if (cap_reg == 0) return 1;
    if (cap_reg > RING_DEPTH) return RING_DEPTH;
    return int'(cap_reg);
  endfunction

  function automatic logic [5:0] step_up(input logic [5:0] i);
    return (int'(i) + 1 >= live_cap()) ? 6'd0 : i + 6'd1;
  endfunction

  function automatic logic [5:0] step_down(input logic [5:0] i);
    return (i == 6'd0) ? 6'(live_cap() - 1) : i - 6'd1;
  endfunction

  task automatic deque_apply_cfg(input logic idx, input logic [6:0] data);
    if (idx == CFG_CAPACITY) begin
      if (dq_empty) cap_reg = data;
    end else begin
      mode_reg = data[0];
    end
  endtask

  // queues the results one operation produces and advances the deque state
  task automatic deque_apply_op(input logic [2:0] o, input logic [31:0] v);
    deque_result_t r;
    logic ok;
    logic fin;
    logic [5:0] i;
    int k;
    r.value_out = '0;
    r.status = STAT_OK;
    r.last = 1'b1;
    ok = (o <= OP_TRAVERSE);
    if (o == OP_INS_FRONT && mode_reg == MODE_IN_RESTRICT) ok = 1'b0;
    if (o == OP_DEL_REAR && mode_reg == MODE_OUT_RESTRICT) ok = 1'b0;
    if (!ok) begin
      r.status = STAT_NOT_ALLOWED;
      results_due.push_back(r);
    end else if (o == OP_INS_REAR || o == OP_INS_FRONT) begin
      if (!dq_empty && step_up(tail_idx) == head_idx) begin
        r.status = STAT_FULL;
      end else if (dq_empty) begin
        head_idx = '0;
        tail_idx = '0;
        dq_empty = 1'b0;
        ring_mem[0] = v;
      end else if (o == OP_INS_REAR) begin
        tail_idx = step_up(tail_idx);
        ring_mem[tail_idx] = v;
      end else begin
        head_idx = step_down(head_idx);
        ring_mem[head_idx] = v;
      end
      results_due.push_back(r);
    end else if (dq_empty) begin
      r.status = STAT_EMPTY;
      results_due.push_back(r);
    end else if (o != OP_TRAVERSE) begin
      r.value_out = (o == OP_DEL_FRONT) ? ring_mem[head_idx] : ring_mem[tail_idx];
      if (head_idx == tail_idx) begin
        head_idx = '0;
        tail_idx = '0;
        dq_empty = 1'b1;
      end else if (o == OP_DEL_FRONT) begin
        head_idx = step_up(head_idx);
      end else begin
        tail_idx = step_down(tail_idx);
      end
      results_due.push_back(r);
    end else begin
      i = head_idx;
      k = 0;
      fin = 1'b0;
      while (!fin) begin
        fin = (i == tail_idx) || (k + 1 == live_cap());
        r.value_out = ring_mem[i];
        r.last = fin;
        results_due.push_back(r);
        k++;
        i = step_up(i);
      end
    end
  endtask

  // one input transfer, then a random gap (possibly none); called at a rising edge
  task automatic issue(input logic [2:0] o, input logic [31:0] v, input logic typed,
                       input logic [1:0] st);
    deque_result_t t;
    int gap;
    int pick;
    in_valid <= 1'b1;
    op <= o;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deque_apply_op(o, v);
    if (typed) begin
      t.value_out = '0;
      t.status = st;
      t.last = 1'b1;
      void'(results_due.pop_back());
      results_due.push_back(t);
    end
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pick = $urandom_range(9);
      if (pick >= 5 && pick < 8) gap = $urandom_range(3, 1);
      else if (pick == 8) gap = $urandom_range(25, 8);
      else if (pick == 9) burst_left = $urandom_range(40, 15);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    deque_apply_cfg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_op(input logic [2:0] o, input logic [31:0] v, input logic typed,
                        input logic [1:0] st);
    stim_row_t row;
    row.kind = ROW_OP;
    row.opc = o;
    row.idx = CFG_CAPACITY;
    row.data = v;
    row.typed = typed;
    row.st = st;
    dir_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic idx, input logic [6:0] data);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.opc = OP_INS_REAR;
    row.idx = idx;
    row.data = 32'(data);
    row.typed = 1'b0;
    row.st = STAT_OK;
    dir_rows.push_back(row);
  endtask

  // output checking and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result value_out=%h status=%0d last=%b",
                   $time, value_out, status, last);
          errors++;
        end else begin
          seen_exp = results_due.pop_front();
          if (value_out !== seen_exp.value_out) begin
            $display("%0t: value_out expected %h actual %h", $time, seen_exp.value_out,
                     value_out);
            errors++;
          end
          if (status !== seen_exp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, seen_exp.status, status);
            errors++;
          end
          if (last !== seen_exp.last) begin
            $display("%0t: last expected %b actual %b", $time, seen_exp.last, last);
            errors++;
          end
        end
      end
      if (stall_left == 0 && calm_left == 0) begin
        pick_out = $urandom_range(9);
        if (pick_out == 0) calm_left = $urandom_range(60, 20);
        else if (pick_out == 1) stall_left = $urandom_range(30, 8);
        else if (pick_out <= 4) stall_left = $urandom_range(3, 1);
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
      else if (calm_left != 0) calm_left--;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int sent;
    int n;
    int ins_pct;
    int p;
    logic [2:0] o;
    logic [6:0] cap;
    stim_row_t row;

    foreach (ring_mem[j]) ring_mem[j] = '0;
    head_idx = '0;
    tail_idx = '0;
    dq_empty = 1'b1;
    cap_reg = 7'd64;
    mode_reg = MODE_OUT_RESTRICT;

    // starts output-restricted with the full ring
    add_op(OP_TRAVERSE, 32'h0, 1'b1, STAT_EMPTY);
    add_op(OP_DEL_FRONT, 32'h0, 1'b1, STAT_EMPTY);
    add_op(OP_DEL_REAR, 32'h0, 1'b1, STAT_NOT_ALLOWED);
    add_op(OP_RSVD_FIRST, 32'h0, 1'b1, STAT_NOT_ALLOWED);
    add_op(OP_RSVD_LAST, 32'hffffffff, 1'b1, STAT_NOT_ALLOWED);
    add_op(OP_INS_REAR, 32'h7fffffff, 1'b1, STAT_OK);
    add_op(OP_INS_FRONT, 32'h80000000, 1'b1, STAT_OK);
    add_op(OP_INS_REAR, 32'hffffffff, 1'b1, STAT_OK);
    add_op(OP_TRAVERSE, 32'h0, 1'b0, STAT_OK);
    add_cfg(CFG_CAPACITY, 7'd2);  // dropped: queue not empty
    add_op(OP_INS_REAR, 32'h00000001, 1'b1, STAT_OK);
    add_op(OP_TRAVERSE, 32'h0, 1'b0, STAT_OK);
    repeat (4) add_op(OP_DEL_FRONT, 32'h0, 1'b0, STAT_OK);
    add_cfg(CFG_CAPACITY, 7'd0);  // behaves as one entry
    add_cfg(CFG_MODE, 7'(MODE_IN_RESTRICT));
    add_op(OP_INS_FRONT, 32'h00001234, 1'b1, STAT_NOT_ALLOWED);
    add_op(OP_INS_REAR, 32'h5a5a5a5a, 1'b1, STAT_OK);
    add_op(OP_INS_REAR, 32'h00000000, 1'b1, STAT_FULL);
    add_op(OP_TRAVERSE, 32'h0, 1'b0, STAT_OK);
    add_op(OP_DEL_REAR, 32'h0, 1'b0, STAT_OK);
    add_op(OP_DEL_REAR, 32'h0, 1'b1, STAT_EMPTY);
    add_cfg(CFG_CAPACITY, 7'd127);  // clamps to the ring size
    add_cfg(CFG_MODE, 7'(MODE_OUT_RESTRICT));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[j]) begin
      row = dir_rows[j];
      if (row.kind == ROW_CFG) write_reg(row.idx, row.data[6:0]);
      else issue(row.opc, row.data, row.typed, row.st);
    end

    sent = 0;
    while (sent < RANDOM_OPS) begin
      if ($urandom_range(3) != 0) begin
        while (!dq_empty) begin
          issue(OP_DEL_FRONT, $urandom, 1'b0, STAT_OK);
          sent++;
        end
      end
      case ($urandom_range(9))
        0: cap = 7'd64;
        1: cap = 7'd1;
        2: cap = 7'd0;
        3: cap = 7'($urandom_range(127, 65));
        4: cap = 7'($urandom_range(63, 9));
        default: cap = 7'($urandom_range(8, 2));
      endcase
      write_reg(CFG_CAPACITY, cap);
      write_reg(CFG_MODE, 7'($urandom_range(1)));
      ins_pct = $urandom_range(80, 30);
      n = (live_cap() >= 32) ? $urandom_range(160, 60) : $urandom_range(50, 20);
      repeat (n) begin
        p = $urandom_range(99);
        if (p < 4) begin
          o = 3'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
        end else if (p < 12) begin
          o = OP_TRAVERSE;
        end else if ($urandom_range(99) < ins_pct) begin
          if ($urandom_range(99) < 15 || mode_reg == MODE_OUT_RESTRICT)
            o = $urandom_range(1) ? OP_INS_FRONT : OP_INS_REAR;
          else
            o = OP_INS_REAR;
        end else begin
          if ($urandom_range(99) < 15 || mode_reg == MODE_IN_RESTRICT)
            o = $urandom_range(1) ? OP_DEL_REAR : OP_DEL_FRONT;
          else
            o = OP_DEL_FRONT;
        end
        issue(o, $urandom, 1'b0, STAT_OK);
        sent++;
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/rcd_pkg.sv
rtl/core/rcd_cell.sv
rtl/core/restricted_circular_deque.sv
tb/restricted_circular_deque_tb.sv
